// File: design/ttcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcc_pkg
// Shared constants and types for the two-table calibration converter.
// ----------------------------------------------------------------------------
package ttcc_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = 5;
    localparam int VAL_W      = 16;
    localparam int ENTRY_W    = 2 * VAL_W;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int DVD_W      = PROD_W + 2;   // 2*prod + den
    localparam int DVS_W      = VAL_W + 1;    // 2*den
    localparam int QSTEP_W    = $clog2(VAL_W);
    localparam int CFG_IDX_W  = 1;

    localparam logic [VAL_W-1:0] SIG_FAIL = 16'hFFFF;
    localparam logic [VAL_W-1:0] VAL_MAX  = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_SAVED_POINTS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_POINTS = 1'b1;

    typedef enum logic [1:0] {
        FUNC_LOAD_SAVED   = 2'd0,
        FUNC_LOAD_CURRENT = 2'd1,
        FUNC_CONVERT      = 2'd2
    } t_func;

endpackage

// File: design/ttcc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcc_div
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// ----------------------------------------------------------------------------
module ttcc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ttcc_pkg::DVD_W-1:0]    i_dividend,
    input  logic [ttcc_pkg::DVS_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [ttcc_pkg::VAL_W-1:0]    o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [ttcc_pkg::QSTEP_W-1:0]  r_step;
    logic [ttcc_pkg::DVD_W-1:0]    r_rem;
    logic [ttcc_pkg::DVD_W-1:0]    r_dsh;
    logic [ttcc_pkg::VAL_W-1:0]    r_q;
    logic                          w_ge;
    logic [ttcc_pkg::DVD_W-1:0]    w_diff;

    // quotient is known to fit in VAL_W bits, so start with divisor << (VAL_W-1)
    assign w_ge   = (r_rem >= r_dsh);
    assign w_diff = r_rem - r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= i_dividend;
                r_dsh  <= ttcc_pkg::DVD_W'(i_divisor) << (ttcc_pkg::VAL_W - 1);
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= w_diff;
                end
                r_q    <= {r_q[ttcc_pkg::VAL_W-2:0], w_ge};
                r_dsh  <= r_dsh >> 1;
                r_step <= r_step + 1'b1;
                if (r_step == ttcc_pkg::QSTEP_W'(ttcc_pkg::VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// File: design/two_table_calibration_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_table_calibration_convert
// Measured value -> signal code (saved table) -> physical value (current
// table), by piecewise linear interpolation with round-half-away rounding.
// ----------------------------------------------------------------------------
// Timing: load items give their result in the cycle after the transfer; a
//   convert walks the saved table, then the current table (shorter when a
//   segment fails or is degenerate), paced by the point-per-cycle table scan
//   and the 16-step shared divider that each interpolation runs through.
// Throughput: one item at a time; busy is high from a convert transfer until
//   its result strobe. Loads can be issued every cycle.
// Reset: synchronous, active low; clears point counts, last physical value and
//   the sequencer. Table contents are undefined until written (no clear pass).
// ----------------------------------------------------------------------------
module two_table_calibration_convert (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item channel
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_func,
    input  logic [3:0]                        i_point_index,
    input  logic [15:0]                       i_signal_value,
    input  logic [15:0]                       i_phys_value,
    // result channel
    output logic                              o_strobe,
    output logic [15:0]                       o_signal_out,
    output logic [15:0]                       o_physical_out,
    output logic                              o_calc_error,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ttcc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ttcc_pkg::CNT_W-1:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,   // point 0 arrives from the table
        S_SCAN,    // one point per cycle, bracket test against previous point
        S_MUL,     // |dx| * |dy|
        S_DIV,     // launch divider
        S_WAIT,    // divider running
        S_FIN      // apply sign and offset, move to next table or finish
    } t_state;

    t_state                          r_state;
    logic                            r_phase;     // 0: saved table, 1: current table
    logic [ttcc_pkg::IDX_W-1:0]      r_idx;       // index of point in read data
    logic [ttcc_pkg::CNT_W-1:0]      r_sav_pts;
    logic [ttcc_pkg::CNT_W-1:0]      r_cur_pts;
    logic [ttcc_pkg::VAL_W-1:0]      r_last_phys;
    logic [ttcc_pkg::VAL_W-1:0]      r_x;         // search key of this walk
    logic [ttcc_pkg::VAL_W-1:0]      r_sig;       // code from the saved walk
    logic [ttcc_pkg::VAL_W-1:0]      r_pa;        // previous point, key column
    logic [ttcc_pkg::VAL_W-1:0]      r_pya;       // previous point, value column
    logic [ttcc_pkg::VAL_W-1:0]      r_y0;
    logic [ttcc_pkg::VAL_W-1:0]      r_dx;
    logic [ttcc_pkg::VAL_W-1:0]      r_dy;
    logic [ttcc_pkg::VAL_W-1:0]      r_ad;
    logic                            r_neg;
    logic [ttcc_pkg::PROD_W-1:0]     r_prod;
    logic [ttcc_pkg::VAL_W-1:0]      r_quo;

    logic                            r_strobe;
    logic [ttcc_pkg::VAL_W-1:0]      r_sig_out;
    logic [ttcc_pkg::VAL_W-1:0]      r_phys_out;
    logic                            r_err_out;

    // table storage, signal code in the upper half, physical value in the lower
    logic [ttcc_pkg::ENTRY_W-1:0]    r_sav_mem [ttcc_pkg::MAX_POINTS];
    logic [ttcc_pkg::ENTRY_W-1:0]    r_cur_mem [ttcc_pkg::MAX_POINTS];
    logic [ttcc_pkg::ENTRY_W-1:0]    r_sav_rd;
    logic [ttcc_pkg::ENTRY_W-1:0]    r_cur_rd;

    logic                            w_accept;
    logic                            w_wr_ok;
    logic [ttcc_pkg::IDX_W-1:0]      w_wr_addr;
    logic [ttcc_pkg::IDX_W-1:0]      w_rd_addr;
    logic [ttcc_pkg::ENTRY_W-1:0]    w_rd;
    logic [ttcc_pkg::CNT_W-1:0]      w_cnt;
    logic                            w_ident;
    logic [ttcc_pkg::IDX_W-1:0]      w_last;
    logic [ttcc_pkg::VAL_W-1:0]      w_sig_col;
    logic [ttcc_pkg::VAL_W-1:0]      w_phys_col;
    logic [ttcc_pkg::VAL_W-1:0]      w_key;
    logic [ttcc_pkg::VAL_W-1:0]      w_yv;
    logic                            w_bracket;
    logic [ttcc_pkg::VAL_W-1:0]      w_res;
    logic                            w_div_start;
    logic [ttcc_pkg::DVD_W-1:0]      w_dividend;
    logic [ttcc_pkg::DVS_W-1:0]      w_divisor;
    logic                            w_div_done;
    logic [ttcc_pkg::VAL_W-1:0]      w_div_q;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;

    // load writes outside the table depth are dropped
    assign w_wr_ok   = (32'(i_point_index) < ttcc_pkg::MAX_POINTS);
    assign w_wr_addr = ttcc_pkg::IDX_W'(i_point_index);

    // read runs one point ahead of the scan; idle/finish states prime point 0
    assign w_rd_addr = (r_state == S_FIRST || r_state == S_SCAN) ? r_idx + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (w_accept && w_wr_ok && i_func == ttcc_pkg::FUNC_LOAD_SAVED) begin
            r_sav_mem[w_wr_addr] <= {i_signal_value, i_phys_value};
        end
        r_sav_rd <= r_sav_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_wr_ok && i_func == ttcc_pkg::FUNC_LOAD_CURRENT) begin
            r_cur_mem[w_wr_addr] <= {i_signal_value, i_phys_value};
        end
        r_cur_rd <= r_cur_mem[w_rd_addr];
    end

    // point decode for the table being walked; empty table = identity line
    assign w_rd    = r_phase ? r_cur_rd : r_sav_rd;
    assign w_cnt   = r_phase ? r_cur_pts : r_sav_pts;
    assign w_ident = (w_cnt == '0);
    assign w_last  = w_ident ? ttcc_pkg::IDX_W'(1) :
                     (32'(w_cnt) >= ttcc_pkg::MAX_POINTS) ?
                         ttcc_pkg::IDX_W'(ttcc_pkg::MAX_POINTS - 1) :
                         ttcc_pkg::IDX_W'(w_cnt - 1'b1);

    always_comb begin
        if (w_ident) begin
            w_sig_col  = (r_idx == '0) ? '0 : ttcc_pkg::VAL_MAX;
            w_phys_col = (r_idx == '0) ? '0 : ttcc_pkg::VAL_MAX;
        end else begin
            w_sig_col  = w_rd[ttcc_pkg::ENTRY_W-1:ttcc_pkg::VAL_W];
            w_phys_col = w_rd[ttcc_pkg::VAL_W-1:0];
        end
    end

    // saved walk searches the physical column, current walk the signal column
    assign w_key = r_phase ? w_sig_col : w_phys_col;
    assign w_yv  = r_phase ? w_phys_col : w_sig_col;

    // segment brackets the key in either direction
    assign w_bracket = ((r_pa >= r_x) && (r_x >= w_key)) ||
                       ((w_key >= r_x) && (r_x >= r_pa));

    assign w_res = r_neg ? (r_y0 - r_quo) : (r_y0 + r_quo);

    // q = (2*|num| + |den|) / (2*|den|): nearest, ties away from zero
    assign w_div_start = (r_state == S_DIV);
    assign w_dividend  = ttcc_pkg::DVD_W'({r_prod, 1'b0}) + ttcc_pkg::DVD_W'(r_ad);
    assign w_divisor   = {r_ad, 1'b0};

    ttcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_sav_pts   <= '0;
            r_cur_pts   <= '0;
            r_last_phys <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ttcc_pkg::CFG_SAVED_POINTS:   r_sav_pts <= i_cfg_data;
                    ttcc_pkg::CFG_CURRENT_POINTS: r_cur_pts <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_func == ttcc_pkg::FUNC_CONVERT) begin
                            r_x     <= i_phys_value;
                            r_phase <= 1'b0;
                            r_idx   <= '0;
                            r_state <= S_FIRST;
                        end else begin
                            // loads and the unused code answer at once
                            r_strobe   <= 1'b1;
                            r_sig_out  <= '0;
                            r_phys_out <= r_last_phys;
                            r_err_out  <= 1'b0;
                        end
                    end
                end

                S_FIRST: begin
                    r_pa  <= w_key;
                    r_pya <= w_yv;
                    r_idx <= r_idx + 1'b1;
                    if (w_cnt == ttcc_pkg::CNT_W'(1)) begin
                        // single point: no segment
                        r_strobe   <= 1'b1;
                        r_sig_out  <= r_phase ? r_sig : ttcc_pkg::SIG_FAIL;
                        r_phys_out <= r_last_phys;
                        r_err_out  <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    if (w_bracket) begin
                        r_y0  <= r_pya;
                        r_dx  <= (r_x >= r_pa) ? (r_x - r_pa) : (r_pa - r_x);
                        r_dy  <= (w_yv >= r_pya) ? (w_yv - r_pya) : (r_pya - w_yv);
                        r_ad  <= (w_key >= r_pa) ? (w_key - r_pa) : (r_pa - w_key);
                        r_neg <= (r_x < r_pa) ^ (w_yv < r_pya) ^ (w_key < r_pa);
                        if (w_key == r_pa) begin
                            // equal endpoints: first endpoint's value
                            r_quo   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end else if (r_idx == w_last) begin
                        r_strobe   <= 1'b1;
                        r_sig_out  <= r_phase ? r_sig : ttcc_pkg::SIG_FAIL;
                        r_phys_out <= r_last_phys;
                        r_err_out  <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_pa  <= w_key;
                        r_pya <= w_yv;
                        r_idx <= r_idx + 1'b1;
                    end
                end

                S_MUL: begin
                    r_prod  <= ttcc_pkg::PROD_W'(r_dx * r_dy);
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    r_state <= S_WAIT;
                end

                S_WAIT: begin
                    if (w_div_done) begin
                        r_quo   <= w_div_q;
                        r_state <= S_FIN;
                    end
                end

                S_FIN: begin
                    if (!r_phase) begin
                        // code found; walk the current table with it
                        r_sig   <= w_res;
                        r_x     <= w_res;
                        r_phase <= 1'b1;
                        r_idx   <= '0;
                        r_state <= S_FIRST;
                    end else begin
                        r_last_phys <= w_res;
                        r_strobe    <= 1'b1;
                        r_sig_out   <= r_sig;
                        r_phys_out  <= w_res;
                        r_err_out   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_signal_out   = r_sig_out;
    assign o_physical_out = r_phys_out;
    assign o_calc_error   = r_err_out;

    // result strobe only ever coincides with the return to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // a convert transfer always occupies the sequencer
    a_convert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == ttcc_pkg::FUNC_CONVERT) |=> busy)
        else $error("convert transfer did not start a walk");

    // other transfers answer next cycle with a clean load result
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func != ttcc_pkg::FUNC_CONVERT) |=>
            (o_strobe && !o_calc_error && o_signal_out == '0 && !busy))
        else $error("load transfer result missing or wrong");

endmodule
